FILE: hw/rtl/bga_pkg.sv
// ----------------------------------------------------------------------------
// bga_pkg
// shared types and constants of the button gesture and autorepeat unit
// ----------------------------------------------------------------------------
`default_nettype none

package bga_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam int NUM_KEYS      = 6;
   localparam int NUM_DIRS      = 4;
   localparam int CFG_BITS      = 16;

   // command codes
   localparam logic [1:0] CMD_PRESS   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_POLL    = 2'd2;

   // key codes
   localparam logic [2:0] KEY_UP    = 3'd0;
   localparam logic [2:0] KEY_DOWN  = 3'd1;
   localparam logic [2:0] KEY_LEFT  = 3'd2;
   localparam logic [2:0] KEY_RIGHT = 3'd3;
   localparam logic [2:0] KEY_OK    = 3'd4;
   localparam logic [2:0] KEY_BACK  = 3'd5;

   // direction slots of the autorepeat state, same order as the key codes
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [1:0] CSR_REPEAT_DELAY = 2'd1;
   localparam logic [1:0] CSR_REPEAT_RATE  = 2'd2;

   // register reset values
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RST   = 16'd300;
   localparam logic [CFG_BITS-1:0] REPEAT_DELAY_RST = 16'd260;
   localparam logic [CFG_BITS-1:0] REPEAT_RATE_RST  = 16'd110;

   // gesture flag bits
   localparam int GF_OK_CONSUMED   = 0;
   localparam int GF_OK_LONG       = 1;
   localparam int GF_BACK_CONSUMED = 2;
   localparam int GF_BACK_LONG     = 3;
   localparam int GF_CHORD         = 4;
   localparam int GF_BITS          = 5;

   typedef struct packed {
      logic [CFG_BITS-1:0] long_thresh;
      logic [CFG_BITS-1:0] first_delay;
      logic [CFG_BITS-1:0] step_period;
   } cfg_type;

   typedef struct packed {
      logic [NUM_KEYS-1:0] held;
      logic [NUM_KEYS-1:0] press_latch;
      logic [NUM_KEYS-1:0] release_latch;
   } key_bits_type;

   typedef struct packed {
      logic        exit_request;
      logic        select_action;
      logic        jump_action;
      logic        inventory_action;
      logic        place_action;
      logic        break_action;
      logic        distribute;
      logic signed [1:0] turn_step;
      logic signed [4:0] forward_step;
      logic signed [1:0] horizontal_step;
      logic signed [1:0] vertical_step;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_BYTES   = (RESULT_BITS + 7) / 8;

endpackage

`default_nettype wire

FILE: hw/rtl/bga_keys.sv
// ----------------------------------------------------------------------------
// bga_keys
// held keys, press and release latches, ok and back press times and holds
// ----------------------------------------------------------------------------
`default_nettype none

module bga_keys
   import bga_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [1:0]           cmd,
   input  wire logic [2:0]           key,
   input  wire logic [TIME_BITS-1:0] now,
   output key_bits_type              key_bits,
   output logic [TIME_BITS-1:0]      ok_press_time,
   output logic [TIME_BITS-1:0]      back_press_time,
   output logic [TIME_BITS-1:0]      ok_hold,
   output logic [TIME_BITS-1:0]      back_hold
);

   key_bits_type         bits_ff, bits_in;
   logic [TIME_BITS-1:0] ok_pt_ff, ok_pt_in, back_pt_ff, back_pt_in;
   logic [TIME_BITS-1:0] ok_hd_ff, ok_hd_in, back_hd_ff, back_hd_in;
   logic [NUM_KEYS-1:0]  key_mask;
   logic                 key_used;

   // only ok and back times are ever read back, so only those are kept
   always_comb begin
      key_used   = key < 3'(NUM_KEYS);
      key_mask   = key_used ? NUM_KEYS'(1) << key : '0;
      bits_in    = bits_ff;
      ok_pt_in   = ok_pt_ff;
      back_pt_in = back_pt_ff;
      ok_hd_in   = ok_hd_ff;
      back_hd_in = back_hd_ff;
      if (load) begin
         unique case (cmd)
            CMD_PRESS: begin
               bits_in.held        = bits_ff.held | key_mask;
               bits_in.press_latch = bits_ff.press_latch | key_mask;
               if (key == KEY_OK) ok_pt_in = now;
               if (key == KEY_BACK) back_pt_in = now;
            end
            CMD_RELEASE: begin
               bits_in.held          = bits_ff.held & ~key_mask;
               bits_in.release_latch = bits_ff.release_latch | key_mask;
               if (key == KEY_OK) ok_hd_in = now - ok_pt_ff;
               if (key == KEY_BACK) back_hd_in = now - back_pt_ff;
            end
            CMD_POLL: begin
               bits_in.press_latch   = '0;
               bits_in.release_latch = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff    <= '0;
         ok_pt_ff   <= '0;
         back_pt_ff <= '0;
         ok_hd_ff   <= '0;
         back_hd_ff <= '0;
      end else begin
         bits_ff    <= bits_in;
         ok_pt_ff   <= ok_pt_in;
         back_pt_ff <= back_pt_in;
         ok_hd_ff   <= ok_hd_in;
         back_hd_ff <= back_hd_in;
      end
   end

   assign key_bits        = bits_ff;
   assign ok_press_time   = ok_pt_ff;
   assign back_press_time = back_pt_ff;
   assign ok_hold         = ok_hd_ff;
   assign back_hold       = back_hd_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bga_poll.sv
// ----------------------------------------------------------------------------
// bga_poll
// poll classification: chord, long and short presses, direction autorepeat
// ----------------------------------------------------------------------------
`default_nettype none

module bga_poll
   import bga_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 play,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire cfg_type              cfg,
   input  wire key_bits_type         key_bits,
   input  wire logic [TIME_BITS-1:0] ok_press_time,
   input  wire logic [TIME_BITS-1:0] back_press_time,
   input  wire logic [TIME_BITS-1:0] ok_hold,
   input  wire logic [TIME_BITS-1:0] back_hold,
   output result_type                result,
   output logic                      exit_latched
);

   localparam int CW = TIME_BITS + 1;

   logic [GF_BITS-1:0]   flags_ff, flags_in;
   logic [TIME_BITS-1:0] nrt_ff [NUM_DIRS];
   logic [TIME_BITS-1:0] nrt_in [NUM_DIRS];
   logic                 exit_ff, exit_in;
   logic [NUM_DIRS-1:0]  dir_fire;
   logic                 ok_held, back_held;
   logic [TIME_BITS-1:0] t_delay, t_rate;

   // wrapped difference a - b is non-negative and at least thr
   function automatic logic reached(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b,
                                    input logic [CFG_BITS-1:0] thr);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return !d[TIME_BITS-1] && (CW'(d) >= CW'(thr));
   endfunction

   always_comb begin
      ok_held   = key_bits.held[KEY_OK];
      back_held = key_bits.held[KEY_BACK];
      t_delay   = TIME_BITS'(cfg.first_delay);
      t_rate    = TIME_BITS'(cfg.step_period);
      flags_in  = flags_ff;
      exit_in   = exit_ff;
      result    = '0;
      dir_fire  = '0;
      for (int i = 0; i < NUM_DIRS; i++) nrt_in[i] = nrt_ff[i];

      if (key_bits.press_latch[KEY_OK]) begin
         flags_in[GF_OK_CONSUMED] = 1'b0;
         flags_in[GF_OK_LONG]     = 1'b0;
      end
      if (key_bits.press_latch[KEY_BACK]) begin
         flags_in[GF_BACK_CONSUMED] = 1'b0;
         flags_in[GF_BACK_LONG]     = 1'b0;
      end

      // chord: exit latches only on the first poll that sees both held
      if (ok_held && back_held) begin
         if (!flags_in[GF_CHORD]) begin
            exit_in            = 1'b1;
            flags_in[GF_CHORD] = 1'b1;
         end
         flags_in[GF_OK_CONSUMED]   = 1'b1;
         flags_in[GF_BACK_CONSUMED] = 1'b1;
      end else if (!ok_held && !back_held) begin
         flags_in[GF_CHORD] = 1'b0;
      end
      if (ok_held && (key_bits.held[NUM_DIRS-1:0] != '0)) flags_in[GF_OK_CONSUMED] = 1'b1;

      // autorepeat for each direction, used by menu and by play with ok held
      for (int i = 0; i < NUM_DIRS; i++) begin
         if (key_bits.press_latch[i]) begin
            dir_fire[i] = 1'b1;
            nrt_in[i]   = now + t_delay;
         end else if (!key_bits.held[i]) begin
            nrt_in[i] = '0;
         end else if (nrt_ff[i] == '0) begin
            dir_fire[i] = 1'b1;
            nrt_in[i]   = now + t_delay;
         end else if (reached(now, nrt_ff[i], '0)) begin
            dir_fire[i] = 1'b1;
            nrt_in[i]   = now + t_rate;
         end
      end

      if (play) begin
         if (ok_held) begin
            if (dir_fire[DIR_DOWN]) result.vertical_step = 2'sb11;
            else if (dir_fire[DIR_UP]) result.vertical_step = 2'sb01;
            if (dir_fire[DIR_RIGHT]) result.horizontal_step = 2'sb01;
            else if (dir_fire[DIR_LEFT]) result.horizontal_step = 2'sb11;
         end else begin
            if (key_bits.held[KEY_DOWN]) result.forward_step = 5'sb11000;
            else if (key_bits.held[KEY_UP]) result.forward_step = 5'sb01000;
            if (key_bits.held[KEY_RIGHT]) result.turn_step = 2'sb11;
            else if (key_bits.held[KEY_LEFT]) result.turn_step = 2'sb01;
            for (int i = 0; i < NUM_DIRS; i++) nrt_in[i] = '0;
         end
         if (ok_held && !flags_in[GF_OK_CONSUMED] && !flags_in[GF_OK_LONG] &&
             reached(now, ok_press_time, cfg.long_thresh)) begin
            result.break_action      = 1'b1;
            flags_in[GF_OK_LONG]     = 1'b1;
            flags_in[GF_OK_CONSUMED] = 1'b1;
         end
         if (key_bits.release_latch[KEY_OK] && !flags_in[GF_OK_CONSUMED] &&
             !flags_in[GF_OK_LONG] && (CW'(ok_hold) < CW'(cfg.long_thresh)))
            result.place_action = 1'b1;
         if (back_held && !flags_in[GF_BACK_CONSUMED] && !flags_in[GF_BACK_LONG] &&
             reached(now, back_press_time, cfg.long_thresh)) begin
            result.inventory_action    = 1'b1;
            flags_in[GF_BACK_LONG]     = 1'b1;
            flags_in[GF_BACK_CONSUMED] = 1'b1;
         end
         if (key_bits.release_latch[KEY_BACK] && !flags_in[GF_BACK_CONSUMED] &&
             !flags_in[GF_BACK_LONG] && (CW'(back_hold) < CW'(cfg.long_thresh)))
            result.jump_action = 1'b1;
      end else begin
         if (dir_fire[DIR_DOWN]) result.vertical_step = 2'sb11;
         else if (dir_fire[DIR_UP]) result.vertical_step = 2'sb01;
         if (dir_fire[DIR_RIGHT]) result.horizontal_step = 2'sb01;
         else if (dir_fire[DIR_LEFT]) result.horizontal_step = 2'sb11;
         result.distribute = ok_held && (dir_fire != '0);
         result.select_action = key_bits.release_latch[KEY_OK] && !flags_in[GF_OK_CONSUMED];
         result.inventory_action = key_bits.release_latch[KEY_BACK] &&
                                   !flags_in[GF_BACK_CONSUMED];
      end
      result.exit_request = exit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         exit_ff  <= 1'b0;
         for (int i = 0; i < NUM_DIRS; i++) nrt_ff[i] <= '0;
      end else if (fire) begin
         flags_ff <= flags_in;
         exit_ff  <= exit_in;
         for (int i = 0; i < NUM_DIRS; i++) nrt_ff[i] <= nrt_in[i];
      end
   end

   assign exit_latched = exit_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/button_gesture_autorepeat_unit.sv
// ----------------------------------------------------------------------------
// button_gesture_autorepeat_unit
// six-button press classifier with long press, chord exit and autorepeat
// ----------------------------------------------------------------------------
// path: a poll's req beat is registered in the input stage, and its result then in
//   the result register that drives rsp_tvalid
// throughput: one beat per cycle; press and release beats never wait on rsp,
//   a poll waits only while the result register holds an untaken result
// reset: synchronous active high; clears key state, gesture flags, repeat
//   times and the exit latch, and loads the register reset values
`default_nettype none

module button_gesture_autorepeat_unit
   import bga_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,  // key[2:0], now_ms[31:0], play_mode, zero pad
   input  wire logic [1:0]            req_tuser,  // command
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [8*RSP_BYTES-1:0]     rsp_tdata,  // vertical_step[1:0], horizontal_step[1:0],
                                                  // forward_step[4:0], turn_step[1:0],
                                                  // distribute, break_action, place_action,
                                                  // inventory_action, jump_action,
                                                  // select_action, exit_request, zero pad
   // register write port
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CFG_BITS-1:0]   csr_wdata
);

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_cmd_ff;
   logic [2:0]           in_key_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 in_play_ff;

   // registers
   cfg_type              cfg_ff, cfg_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff;

   logic                 is_poll, out_free, advance, poll_fire;
   key_bits_type         key_bits;
   logic [TIME_BITS-1:0] ok_pt, back_pt, ok_hd, back_hd;
   result_type           poll_result;
   logic                 exit_latched;

   // pipeline handshake: events always drain, a poll needs room in rsp
   assign is_poll    = in_cmd_ff == CMD_POLL;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!is_poll || out_free);
   assign poll_fire  = advance && is_poll;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (poll_fire) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // register decode; writes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   cfg_in.long_thresh = csr_wdata;
            CSR_REPEAT_DELAY: cfg_in.first_delay = csr_wdata;
            CSR_REPEAT_RATE:  cfg_in.step_period = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{long_thresh: LONG_PRESS_RST,
                           first_delay: REPEAT_DELAY_RST,
                           step_period: REPEAT_RATE_RST};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_key_ff  <= req_tdata[2:0];
         in_now_ff  <= req_tdata[3 +: TIME_BITS];
         in_play_ff <= req_tdata[35];
      end
      if (poll_fire) rsp_data_ff <= poll_result;
   end

   bga_keys #(
      .TIME_BITS(TIME_BITS)
   ) u_keys (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .cmd             (in_cmd_ff),
      .key             (in_key_ff),
      .now             (in_now_ff),
      .key_bits        (key_bits),
      .ok_press_time   (ok_pt),
      .back_press_time (back_pt),
      .ok_hold         (ok_hd),
      .back_hold       (back_hd)
   );

   bga_poll #(
      .TIME_BITS(TIME_BITS)
   ) u_poll (
      .clock           (clock),
      .reset           (reset),
      .fire            (poll_fire),
      .play            (in_play_ff),
      .now             (in_now_ff),
      .cfg             (cfg_ff),
      .key_bits        (key_bits),
      .ok_press_time   (ok_pt),
      .back_press_time (back_pt),
      .ok_hold         (ok_hd),
      .back_hold       (back_hd),
      .result          (poll_result),
      .exit_latched    (exit_latched)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(8*RSP_BYTES-RESULT_BITS)'(0), rsp_data_ff};

   // a poll leaving the input stage always lands in the result register
   a_poll_lands: assert property (@(posedge clock) disable iff (reset)
      poll_fire |=> rsp_valid_ff && (rsp_data_ff == $past(poll_result)))
      else $error("poll beat did not reach the result register");

   // the exit latch never clears once set
   a_exit_sticky: assert property (@(posedge clock) disable iff (reset)
      exit_latched |=> exit_latched)
      else $error("exit latch dropped");

   // the input side only stalls behind a poll blocked by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && is_poll && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked poll");

   // key events passing through leave a waiting result untouched
   a_event_keeps_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_poll && rsp_valid_ff && !rsp_tready) |=>
         rsp_valid_ff && $stable(rsp_data_ff))
      else $error("key event disturbed a waiting result");

endmodule

`default_nettype wire

FILE: test/button_gesture_autorepeat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_autorepeat_checker
// watches the request, result and register ports of the gesture unit, keeps
// its own copy of key state and registers, predicts each poll result and
// compares the results in order, field by field
// ----------------------------------------------------------------------------

module button_gesture_autorepeat_checker
   import bga_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [39:0]           req_tdata,  // key[2:0], now_ms[31:0], play_mode, zero pad
   input  wire logic [1:0]            req_tuser,  // command
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [8*RSP_BYTES-1:0] rsp_tdata, // result_type fields, lowest first
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CFG_BITS-1:0]   csr_wdata,
   output int                         mismatches,
   output int                         outstanding,
   output int                         results_checked
);

   localparam int SHOW_LIMIT = 40;

   logic [CFG_BITS-1:0] long_ms, delay_ms, rate_ms;
   logic [NUM_KEYS-1:0] keys_down, new_presses, new_releases;
   logic [31:0]         pressed_at [NUM_KEYS];
   logic [31:0]         held_for [NUM_KEYS];
   logic [31:0]         next_step_at [NUM_DIRS];
   logic [GF_BITS-1:0]  gesture;
   logic                exit_sticky;

   result_type gesture_results_due [$];
   result_type got, want;

   // a - b is non-negative in wrapping time and at least thr
   function automatic logic reached(logic [31:0] a, logic [31:0] b, logic [31:0] thr);
      logic [31:0] d;
      d = a - b;
      return !d[31] && (d >= thr);
   endfunction

   // autorepeat of one direction; updates its next step time
   function automatic logic dir_step(int d, logic [31:0] now, logic [NUM_KEYS-1:0] plat,
                                     logic [NUM_KEYS-1:0] held);
      if (plat[d]) begin
         next_step_at[d] = now + delay_ms;
         return 1'b1;
      end
      if (!held[d]) begin
         next_step_at[d] = '0;
         return 1'b0;
      end
      // zero reads as idle, so a wrapped repeat time fires as a first step
      if (next_step_at[d] == '0) begin
         next_step_at[d] = now + delay_ms;
         return 1'b1;
      end
      if (reached(now, next_step_at[d], 32'd0)) begin
         next_step_at[d] = now + rate_ms;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void classify_beat(logic [1:0] cmd, logic [2:0] key, logic [31:0] now,
                                         logic play);
      result_type          r;
      logic [NUM_KEYS-1:0] held, plat, rlat;
      logic                ok_held, back_held;
      r = '0;
      case (cmd)
         CMD_PRESS: begin
            if (key <= KEY_BACK) begin
               keys_down[key] = 1'b1;
               new_presses[key] = 1'b1;
               pressed_at[key] = now;
            end
         end
         CMD_RELEASE: begin
            if (key <= KEY_BACK) begin
               keys_down[key] = 1'b0;
               new_releases[key] = 1'b1;
               held_for[key] = now - pressed_at[key];
            end
         end
         CMD_POLL: begin
            held = keys_down;
            plat = new_presses;
            rlat = new_releases;
            new_presses = '0;
            new_releases = '0;
            ok_held = held[KEY_OK];
            back_held = held[KEY_BACK];
            if (plat[KEY_OK]) begin
               gesture[GF_OK_CONSUMED] = 1'b0;
               gesture[GF_OK_LONG] = 1'b0;
            end
            if (plat[KEY_BACK]) begin
               gesture[GF_BACK_CONSUMED] = 1'b0;
               gesture[GF_BACK_LONG] = 1'b0;
            end
            if (ok_held && back_held) begin
               if (!gesture[GF_CHORD]) begin
                  exit_sticky = 1'b1;
                  gesture[GF_CHORD] = 1'b1;
               end
               gesture[GF_OK_CONSUMED] = 1'b1;
               gesture[GF_BACK_CONSUMED] = 1'b1;
            end else if (!ok_held && !back_held) begin
               gesture[GF_CHORD] = 1'b0;
            end
            if (ok_held && (held[3:0] != '0)) gesture[GF_OK_CONSUMED] = 1'b1;

            if (play) begin
               if (ok_held) begin
                  if (dir_step(int'(KEY_UP), now, plat, held))    r.vertical_step = 2'sd1;
                  if (dir_step(int'(KEY_DOWN), now, plat, held))  r.vertical_step = -2'sd1;
                  if (dir_step(int'(KEY_LEFT), now, plat, held))  r.horizontal_step = -2'sd1;
                  if (dir_step(int'(KEY_RIGHT), now, plat, held)) r.horizontal_step = 2'sd1;
               end else begin
                  if (held[KEY_UP])    r.forward_step = 5'sd8;
                  if (held[KEY_DOWN])  r.forward_step = -5'sd8;
                  if (held[KEY_LEFT])  r.turn_step = 2'sd1;
                  if (held[KEY_RIGHT]) r.turn_step = -2'sd1;
                  for (int i = 0; i < NUM_DIRS; i++) next_step_at[i] = '0;
               end
               if (ok_held && !gesture[GF_OK_CONSUMED] && !gesture[GF_OK_LONG] &&
                   reached(now, pressed_at[KEY_OK], 32'(long_ms))) begin
                  r.break_action = 1'b1;
                  gesture[GF_OK_LONG] = 1'b1;
                  gesture[GF_OK_CONSUMED] = 1'b1;
               end
               if (rlat[KEY_OK] && !gesture[GF_OK_CONSUMED] && !gesture[GF_OK_LONG] &&
                   held_for[KEY_OK] < long_ms)
                  r.place_action = 1'b1;
               if (back_held && !gesture[GF_BACK_CONSUMED] && !gesture[GF_BACK_LONG] &&
                   reached(now, pressed_at[KEY_BACK], 32'(long_ms))) begin
                  r.inventory_action = 1'b1;
                  gesture[GF_BACK_LONG] = 1'b1;
                  gesture[GF_BACK_CONSUMED] = 1'b1;
               end
               if (rlat[KEY_BACK] && !gesture[GF_BACK_CONSUMED] && !gesture[GF_BACK_LONG] &&
                   held_for[KEY_BACK] < long_ms)
                  r.jump_action = 1'b1;
            end else begin
               if (dir_step(int'(KEY_UP), now, plat, held)) begin
                  r.vertical_step = 2'sd1;
                  r.distribute = ok_held;
               end
               if (dir_step(int'(KEY_DOWN), now, plat, held)) begin
                  r.vertical_step = -2'sd1;
                  r.distribute = ok_held;
               end
               if (dir_step(int'(KEY_LEFT), now, plat, held)) begin
                  r.horizontal_step = -2'sd1;
                  r.distribute = ok_held;
               end
               if (dir_step(int'(KEY_RIGHT), now, plat, held)) begin
                  r.horizontal_step = 2'sd1;
                  r.distribute = ok_held;
               end
               if (rlat[KEY_OK] && !gesture[GF_OK_CONSUMED]) r.select_action = 1'b1;
               if (rlat[KEY_BACK] && !gesture[GF_BACK_CONSUMED]) r.inventory_action = 1'b1;
            end
            r.exit_request = exit_sticky;
            gesture_results_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < SHOW_LIMIT) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(string field_name, int got_v, int want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                   results_checked, field_name, got_v, want_v));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatches = 0;
         results_checked = 0;
         long_ms = LONG_PRESS_RST;
         delay_ms = REPEAT_DELAY_RST;
         rate_ms = REPEAT_RATE_RST;
         keys_down = '0;
         new_presses = '0;
         new_releases = '0;
         gesture = '0;
         exit_sticky = 1'b0;
         for (int i = 0; i < NUM_KEYS; i++) begin
            pressed_at[i] = '0;
            held_for[i] = '0;
         end
         for (int i = 0; i < NUM_DIRS; i++) next_step_at[i] = '0;
         gesture_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LONG_PRESS:   long_ms = csr_wdata;
               CSR_REPEAT_DELAY: delay_ms = csr_wdata;
               CSR_REPEAT_RATE:  rate_ms = csr_wdata;
               default: ;
            endcase
         end
         // compare before predicting so a beat accepted now never meets its own result
         if (rsp_tvalid && rsp_tready) begin
            if (gesture_results_due.size() == 0) begin
               report_mismatch("result beat with no poll waiting");
            end else begin
               got = rsp_tdata[RESULT_BITS-1:0];
               want = gesture_results_due.pop_front();
               check_field("vertical_step", int'(got.vertical_step), int'(want.vertical_step));
               check_field("horizontal_step", int'(got.horizontal_step),
                           int'(want.horizontal_step));
               check_field("forward_step", int'(got.forward_step), int'(want.forward_step));
               check_field("turn_step", int'(got.turn_step), int'(want.turn_step));
               check_field("distribute", int'(got.distribute), int'(want.distribute));
               check_field("break_action", int'(got.break_action), int'(want.break_action));
               check_field("place_action", int'(got.place_action), int'(want.place_action));
               check_field("inventory_action", int'(got.inventory_action),
                           int'(want.inventory_action));
               check_field("jump_action", int'(got.jump_action), int'(want.jump_action));
               check_field("select_action", int'(got.select_action),
                           int'(want.select_action));
               check_field("exit_request", int'(got.exit_request), int'(want.exit_request));
               results_checked++;
            end
         end
         if (req_tvalid && req_tready)
            classify_beat(req_tuser, req_tdata[2:0], req_tdata[34:3], req_tdata[35]);
      end
      outstanding <= gesture_results_due.size();
   end

endmodule

FILE: test/button_gesture_autorepeat_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_autorepeat_unit_test
// drives press, release and poll beats into the gesture unit under several
// register settings, with random gaps and result stalls; the checker predicts
// and compares every poll result, this module gives the verdict
// ----------------------------------------------------------------------------

module button_gesture_autorepeat_unit_test;
   import bga_pkg::*;

   // codes the block ignores
   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam logic [2:0] KEY_SPARE_LO = 3'd6;
   localparam logic [2:0] KEY_SPARE_HI = 3'd7;

   localparam int BEATS_PER_PHASE = 250;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [39:0]               req_tdata = '0;
   logic [1:0]                req_tuser = CMD_POLL;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [8*RSP_BYTES-1:0]    rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [1:0]                csr_index = CSR_LONG_PRESS;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   int          mismatches, polls_in_flight, results_checked;
   int          req_calm = 0;
   int          rsp_calm = 0;
   int          ready_hold = 0;
   int          stall_len;
   int          beats_counted = 0;
   int          settings_used = 0;
   int          tick_max = 150;
   logic [31:0] now_stamp = 32'd10000;

   always #5 clock = ~clock;

   button_gesture_autorepeat_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   button_gesture_autorepeat_checker gesture_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (polls_in_flight),
      .results_checked (results_checked)
   );

   // gap length: mostly none, some short, a few long; now and then a calm
   // stretch with no gaps at all
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // result side back-pressure, held for the picked number of cycles
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         stall_len = pick_gap(rsp_calm);
         rsp_tready <= (stall_len == 0);
         ready_hold <= (stall_len == 0) ? 0 : stall_len - 1;
      end
   end

   // one request beat, optionally preceded by an idle gap; valid stays high
   // into the next beat when there is no gap
   task automatic send_beat(input logic [1:0] cmd, input logic [2:0] key,
                            input logic [31:0] stamp, input logic play);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, play, stamp, key};
      do @(posedge clock); while (!req_tready);
      // ignored beats do not count toward the phase size
      if (cmd == CMD_POLL || (cmd != CMD_UNUSED && key <= KEY_BACK)) beats_counted++;
   endtask

   // drain: wait until no poll is in flight, then idle on so press and release beats drain too
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (polls_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic set_config(input logic [CFG_BITS-1:0] long_v,
                             input logic [CFG_BITS-1:0] delay_v,
                             input logic [CFG_BITS-1:0] rate_v);
      settle();
      write_reg(CSR_LONG_PRESS, long_v);
      write_reg(CSR_REPEAT_DELAY, delay_v);
      write_reg(CSR_REPEAT_RATE, rate_v);
      @(posedge clock);
      csr_we <= 1'b0;
      // time steps scaled so thresholds are crossed within a few polls
      tick_max = (int'(long_v) + int'(delay_v)) / 4 + 2;
      settings_used++;
   endtask

   task automatic advance_time();
      if ($urandom_range(0, 99) < 2) now_stamp = $urandom();
      else now_stamp = now_stamp + $urandom_range(0, tick_max);
   endtask

   task automatic poll_once(input logic mode);
      logic play;
      advance_time();
      play = ($urandom_range(0, 9) == 0) ? ~mode : mode;
      send_beat(CMD_POLL, 3'($urandom_range(0, 7)), now_stamp, play);
   endtask

   // press a few keys, poll while they are held, release most of them
   task automatic run_episode();
      logic [2:0] pressed_keys [$];
      logic [2:0] k;
      logic       mode;
      int         idx;
      mode = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) begin
         k = 3'($urandom_range(0, 5));
         pressed_keys.push_back(k);
         advance_time();
         send_beat(CMD_PRESS, k, now_stamp, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 1)) poll_once(mode);
      end
      repeat ($urandom_range(1, 6)) poll_once(mode);
      while (pressed_keys.size() > 0) begin
         idx = $urandom_range(0, pressed_keys.size() - 1);
         k = pressed_keys[idx];
         pressed_keys.delete(idx);
         // some keys stay down into later episodes
         if ($urandom_range(0, 5) != 0) begin
            advance_time();
            send_beat(CMD_RELEASE, k, now_stamp, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) poll_once(mode);
         end
      end
      repeat ($urandom_range(1, 2)) poll_once(mode);
   endtask

   task automatic run_phase();
      int start_count;
      start_count = beats_counted;
      while (beats_counted - start_count < BEATS_PER_PHASE) begin
         if ($urandom_range(0, 99) < 15) begin
            // noise: any command, any key, any mapping
            advance_time();
            send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), now_stamp,
                      1'($urandom_range(0, 1)));
         end else begin
            run_episode();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset register values
      send_beat(CMD_POLL, KEY_SPARE_HI, 32'd1000, 1'b0);       // idle poll, key ignored
      send_beat(CMD_RELEASE, KEY_OK, 32'd50, 1'b0);            // release without press
      send_beat(CMD_POLL, KEY_UP, 32'd60, 1'b0);               // menu select
      send_beat(CMD_PRESS, KEY_SPARE_LO, 32'd70, 1'b0);        // unused keys
      send_beat(CMD_RELEASE, KEY_SPARE_HI, 32'd80, 1'b1);
      send_beat(CMD_UNUSED, KEY_UP, 32'd90, 1'b1);             // unused command
      // opposite directions held together, in menu mode and then in play
      send_beat(CMD_PRESS, KEY_UP, 32'd2000, 1'b0);
      send_beat(CMD_PRESS, KEY_DOWN, 32'd2000, 1'b0);
      send_beat(CMD_POLL, KEY_UP, 32'd2000, 1'b0);
      send_beat(CMD_POLL, KEY_UP, 32'd2100, 1'b0);
      send_beat(CMD_POLL, KEY_UP, 32'd2260, 1'b1);             // play without ok
      send_beat(CMD_RELEASE, KEY_UP, 32'd2300, 1'b0);
      send_beat(CMD_RELEASE, KEY_DOWN, 32'd2300, 1'b0);
      // ok long press, then ok short press
      send_beat(CMD_PRESS, KEY_OK, 32'd3000, 1'b1);
      send_beat(CMD_POLL, KEY_OK, 32'd3300, 1'b1);
      send_beat(CMD_RELEASE, KEY_OK, 32'd3400, 1'b1);
      send_beat(CMD_PRESS, KEY_OK, 32'd3500, 1'b1);
      send_beat(CMD_RELEASE, KEY_OK, 32'd3600, 1'b1);
      send_beat(CMD_POLL, KEY_OK, 32'd3600, 1'b1);
      // back long press, then back short press
      send_beat(CMD_PRESS, KEY_BACK, 32'd4000, 1'b1);
      send_beat(CMD_POLL, KEY_BACK, 32'd4300, 1'b1);
      send_beat(CMD_RELEASE, KEY_BACK, 32'd4400, 1'b1);
      send_beat(CMD_PRESS, KEY_BACK, 32'd4500, 1'b1);
      send_beat(CMD_RELEASE, KEY_BACK, 32'd4550, 1'b1);
      send_beat(CMD_POLL, KEY_BACK, 32'd4550, 1'b1);
      // ok plus back chord sets the sticky exit
      send_beat(CMD_PRESS, KEY_OK, 32'd5000, 1'b0);
      send_beat(CMD_PRESS, KEY_BACK, 32'd5000, 1'b0);
      send_beat(CMD_POLL, KEY_OK, 32'd5000, 1'b0);
      send_beat(CMD_PRESS, KEY_UP, 32'd5050, 1'b1);           // pitch with ok held
      send_beat(CMD_POLL, KEY_OK, 32'd5050, 1'b1);
      send_beat(CMD_RELEASE, KEY_UP, 32'd5100, 1'b0);
      send_beat(CMD_RELEASE, KEY_OK, 32'd5100, 1'b0);
      send_beat(CMD_RELEASE, KEY_BACK, 32'd5100, 1'b0);
      send_beat(CMD_POLL, KEY_OK, 32'd5100, 1'b0);
      // repeat time that wraps to zero fires again as a first step
      send_beat(CMD_PRESS, KEY_LEFT, 32'hFFFF_FE00, 1'b0);
      send_beat(CMD_POLL, KEY_LEFT, 32'hFFFF_FEFC, 1'b0);
      send_beat(CMD_POLL, KEY_LEFT, 32'hFFFF_FF00, 1'b0);
      send_beat(CMD_RELEASE, KEY_LEFT, 32'd5, 1'b0);
      send_beat(CMD_POLL, KEY_RIGHT, 32'hFFFF_FFFF, 1'b1);

      // random part over several register settings
      run_phase();
      set_config(16'd1, 16'd1, 16'd1);
      run_phase();
      now_stamp = 32'hFFFE_0000;                                // wraps during the phase
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase();
      set_config(16'd0, 16'd0, 16'd0);                          // everything long, rate fires always
      run_phase();
      set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 65535)));
      run_phase();
      set_config(16'($urandom_range(20, 600)), 16'($urandom_range(20, 600)),
                 16'($urandom_range(20, 600)));
      run_phase();

      settle();
      repeat (8) @(posedge clock);

      $display("covered %0d counted beats and %0d poll results over %0d register settings",
               beats_counted, results_checked, settings_used + 1);
      $display("included chords, long and short presses, autorepeat, time wrap, ignored codes");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
